FILE: rtl/rpa_pkg.sv
package rpa_pkg;

  // request kinds
  localparam logic [2:0] REQ_OCCUPY    = 3'd0;
  localparam logic [2:0] REQ_ASSIGN    = 3'd1;
  localparam logic [2:0] REQ_RELEASE   = 3'd2;
  localparam logic [2:0] REQ_LIST_FREE = 3'd3;
  localparam logic [2:0] REQ_LIST_HELD = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NONE_FREE = 3'd1;
  localparam logic [2:0] ST_NOT_HELD  = 3'd2;
  localparam logic [2:0] ST_BAD_UNIT  = 3'd3;
  localparam logic [2:0] ST_ENTRY     = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;

  localparam int TOKEN_W = 16;
  localparam int UNIT_W  = 8;

  // free-order queue cell control
  typedef struct packed {
    logic shift;  // take the right neighbor's entry
    logic load;   // take the broadcast insert value
  } fq_ctl_t;

  // held ring cell control
  typedef struct packed {
    logic rot;    // take the next cell's flag and token
    logic set;    // mark held, capture token
    logic clr;    // mark free
  } hc_ctl_t;

endpackage

FILE: rtl/room_pool_allocator_unit.sv
// Occupy, assign, release: one result, valid the cycle after the request is taken.
// Occupy then walks the whole free-order queue, one cell per cycle, busy meanwhile.
// List free walks the free order, list held the held ring (one empty result if none);
// one rotation step of the cell row per cycle, stalled while the output is full.
// Reset (rst, synchronous): every unit free in ascending order, nothing held;
// the token store is not cleared.
module room_pool_allocator_unit #(
  parameter int ROOMS      = 20,
  parameter int FIRST_ROOM = 101
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // guest_token[15:0], unit_number[23:16]
  input  logic [2:0]  s_tuser,   // req_type[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // unit_out[7:0], guest_out[23:8]
  output logic [2:0]  m_tuser,   // status[2:0]
  output logic        m_tlast
);
  import rpa_pkg::*;

  localparam int IW = (ROOMS > 1) ? $clog2(ROOMS) : 1;
  localparam int CW = $clog2(ROOMS + 1);

  typedef enum logic [1:0] {IDLE, DROP, LFREE, LHELD} state_t;

  state_t               state;
  logic [CW-1:0]        fcnt;
  logic [CW-1:0]        step;
  logic [CW-1:0]        ent;
  logic [IW-1:0]        drop_idx;

  // request fields
  logic [2:0]           req;
  logic [TOKEN_W-1:0]   tok;
  logic [UNIT_W-1:0]    unum;
  assign req  = s_tuser;
  assign tok  = s_tdata[15:0];
  assign unum = s_tdata[23:16];

  // pool index of the request's unit
  logic [8:0]           udiff;
  logic                 in_range;
  logic [IW-1:0]        idx;
  logic                 held_at_idx;

  logic [IW-1:0]        fq_val [ROOMS];
  fq_ctl_t              fq_ctl [ROOMS];
  logic [ROOMS-1:0]     held_vec;
  logic [TOKEN_W-1:0]   hg [ROOMS];
  hc_ctl_t              hc_ctl [ROOMS];

  logic [IW-1:0]        head;
  logic                 out_free;
  logic                 accept;
  logic [CW-1:0]        held_cnt;

  assign udiff       = {1'b0, unum} - 9'(FIRST_ROOM);
  assign in_range    = !udiff[8] && (udiff < 9'(ROOMS));
  assign idx         = udiff[IW-1:0];
  assign held_at_idx = in_range && held_vec[idx];

  assign head     = fq_val[0];
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;
  assign held_cnt = CW'(ROOMS) - fcnt;

  // broadcast controls for the cell rows
  logic                 fq_shift;
  logic                 fq_ins;
  logic [CW-1:0]        fq_pos;
  logic [IW-1:0]        fq_ins_val;
  logic                 hc_rot;
  logic                 hc_set;
  logic                 hc_clr;
  logic [IW-1:0]        hc_idx;
  logic                 emit;     // a new result enters the output register

  always_comb begin
    fq_shift   = 1'b0;
    fq_ins     = 1'b0;
    fq_pos     = fcnt - CW'(1);
    fq_ins_val = head;
    hc_rot     = 1'b0;
    hc_set     = 1'b0;
    hc_clr     = 1'b0;
    hc_idx     = idx;
    emit       = 1'b0;
    unique case (state)
      IDLE: begin
        if (accept) begin
          case (req)
            REQ_OCCUPY: begin
              emit   = 1'b1;
              hc_set = in_range && !held_at_idx;
            end
            REQ_ASSIGN: begin
              emit = 1'b1;
              if (fcnt != '0) begin
                fq_shift = 1'b1;
                hc_set   = 1'b1;
                hc_idx   = head;
              end
            end
            REQ_RELEASE: begin
              emit = 1'b1;
              if (held_at_idx && fcnt < CW'(ROOMS)) begin
                fq_ins     = 1'b1;
                fq_pos     = fcnt;
                fq_ins_val = idx;
                hc_clr     = 1'b1;
              end
            end
            REQ_LIST_FREE: begin
              emit = (fcnt == '0);
            end
            REQ_LIST_HELD: begin
              emit = (fcnt == CW'(ROOMS));
            end
            default: ;
          endcase
        end
      end
      DROP: begin
        // rotate head to tail, dropping the occupied unit
        fq_shift = 1'b1;
        fq_ins   = (head != drop_idx);
      end
      LFREE: begin
        fq_shift = out_free;
        fq_ins   = out_free;
        emit     = out_free;
      end
      LHELD: begin
        hc_rot = out_free;
        emit   = out_free && held_vec[0];
      end
      default: ;
    endcase
  end

  // cell rows: free-order queue and held ring
  for (genvar i = 0; i < ROOMS; i++) begin : g_cell
    localparam int RN = (i == ROOMS - 1) ? i : i + 1;
    localparam int HN = (i == ROOMS - 1) ? 0 : i + 1;

    assign fq_ctl[i].shift = fq_shift;
    assign fq_ctl[i].load  = fq_ins && (fq_pos == CW'(i));
    assign hc_ctl[i].rot   = hc_rot;
    assign hc_ctl[i].set   = hc_set && (hc_idx == IW'(i));
    assign hc_ctl[i].clr   = hc_clr && (hc_idx == IW'(i));

    rpa_free_cell #(.W(IW)) u_free (
      .clk       (clk),
      .rst       (rst),
      .init_val  (IW'(i)),
      .ctl       (fq_ctl[i]),
      .right_val (fq_val[RN]),
      .ins_val   (fq_ins_val),
      .val       (fq_val[i])
    );

    rpa_held_cell u_held (
      .clk        (clk),
      .rst        (rst),
      .ctl        (hc_ctl[i]),
      .next_flag  (held_vec[HN]),
      .next_guest (hg[HN]),
      .tok        (tok),
      .flag       (held_vec[i]),
      .guest      (hg[i])
    );
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      fcnt     <= CW'(ROOMS);
      step     <= '0;
      ent      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // output valid: set by a new result, dropped once taken
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            case (req)
              REQ_OCCUPY: begin
                m_tlast  <= 1'b1;
                if (in_range && !held_at_idx) begin
                  m_tuser  <= ST_OK;
                  m_tdata  <= {16'd0, unum};
                  drop_idx <= idx;
                  step     <= fcnt;
                  state    <= DROP;
                end else begin
                  m_tuser <= ST_BAD_UNIT;
                  m_tdata <= '0;
                end
              end
              REQ_ASSIGN: begin
                m_tlast  <= 1'b1;
                if (fcnt != '0) begin
                  m_tuser <= ST_OK;
                  m_tdata <= {16'd0, 8'(FIRST_ROOM) + 8'(head)};
                  fcnt    <= fcnt - CW'(1);
                end else begin
                  m_tuser <= ST_NONE_FREE;
                  m_tdata <= '0;
                end
              end
              REQ_RELEASE: begin
                m_tlast  <= 1'b1;
                if (held_at_idx && fcnt < CW'(ROOMS)) begin
                  m_tuser <= ST_OK;
                  m_tdata <= {16'd0, unum};
                  fcnt    <= fcnt + CW'(1);
                end else begin
                  m_tuser <= ST_NOT_HELD;
                  m_tdata <= '0;
                end
              end
              REQ_LIST_FREE: begin
                if (fcnt == '0) begin
                  m_tlast  <= 1'b1;
                  m_tuser  <= ST_EMPTY;
                  m_tdata  <= '0;
                end else begin
                  step  <= '0;
                  state <= LFREE;
                end
              end
              REQ_LIST_HELD: begin
                if (fcnt == CW'(ROOMS)) begin
                  m_tlast  <= 1'b1;
                  m_tuser  <= ST_EMPTY;
                  m_tdata  <= '0;
                end else begin
                  step  <= '0;
                  ent   <= '0;
                  state <= LHELD;
                end
              end
              default: ;
            endcase
          end
        end
        DROP: begin
          if (head == drop_idx) begin
            fcnt <= fcnt - CW'(1);
          end
          step <= step - CW'(1);
          if (step == CW'(1)) begin
            state <= IDLE;
          end
        end
        LFREE: begin
          if (out_free) begin
            m_tuser  <= ST_ENTRY;
            m_tdata  <= {16'd0, 8'(FIRST_ROOM) + 8'(head)};
            m_tlast  <= (step == fcnt - CW'(1));
            step     <= step + CW'(1);
            if (step == fcnt - CW'(1)) begin
              state <= IDLE;
            end
          end
        end
        LHELD: begin
          if (out_free) begin
            if (held_vec[0]) begin
              m_tuser  <= ST_ENTRY;
              m_tdata  <= {hg[0], 8'(FIRST_ROOM) + 8'(step)};
              m_tlast  <= (ent == held_cnt - CW'(1));
              ent      <= ent + CW'(1);
            end
            step <= step + CW'(1);
            if (step == CW'(ROOMS - 1)) begin
              state <= IDLE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // every unit is either held or in the free order
  a_pool_balance: assert property (@(posedge clk) disable iff (rst)
    (state != DROP) |-> ($countones(held_vec) + int'(fcnt) == ROOMS))
    else $error("held and free counts do not cover the pool");

  // free count never exceeds the pool
  a_fcnt_range: assert property (@(posedge clk) disable iff (rst)
    fcnt <= CW'(ROOMS))
    else $error("free count out of range");

  // held listing never emits more entries than units held
  a_held_entries: assert property (@(posedge clk) disable iff (rst)
    (state == LHELD) |-> (ent <= held_cnt))
    else $error("held list ran past held count");

  // an occupy that succeeds leaves the sequencer walking the free order
  a_occupy_walk: assert property (@(posedge clk) disable iff (rst)
    (accept && req == REQ_OCCUPY && in_range && !held_at_idx) |=> (state == DROP))
    else $error("occupy did not start the free-order walk");

endmodule

FILE: rtl/rpa_free_cell.sv
module rpa_free_cell #(
  parameter int W = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [W-1:0]    init_val,
  input  rpa_pkg::fq_ctl_t ctl,
  input  logic [W-1:0]    right_val,
  input  logic [W-1:0]    ins_val,
  output logic [W-1:0]    val
);

  // one free-order slot: insert wins over shift
  always_ff @(posedge clk) begin
    if (rst) begin
      val <= init_val;
    end else if (ctl.load) begin
      val <= ins_val;
    end else if (ctl.shift) begin
      val <= right_val;
    end
  end

endmodule

FILE: rtl/rpa_held_cell.sv
module rpa_held_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  rpa_pkg::hc_ctl_t              ctl,
  input  logic                          next_flag,
  input  logic [rpa_pkg::TOKEN_W-1:0]   next_guest,
  input  logic [rpa_pkg::TOKEN_W-1:0]   tok,
  output logic                          flag,
  output logic [rpa_pkg::TOKEN_W-1:0]   guest
);

  // held flag, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else if (ctl.set) begin
      flag <= 1'b1;
    end else if (ctl.clr) begin
      flag <= 1'b0;
    end else if (ctl.rot) begin
      flag <= next_flag;
    end
  end

  // guest token, meaningful only while held
  always_ff @(posedge clk) begin
    if (ctl.set) begin
      guest <= tok;
    end else if (ctl.rot) begin
      guest <= next_guest;
    end
  end

endmodule

FILE: sim/room_pool_allocator_unit_tb.sv
`timescale 1ns / 100ps

module room_pool_allocator_unit_tb;
  import rpa_pkg::*;

  localparam int ROOMS          = 20;
  localparam int FIRST_ROOM     = 101;
  localparam int RANDOM_ITEMS   = 420;
  localparam int HOLD_OFF_AT    = 150;   // requests taken before the long receiver stall
  localparam int HOLD_OFF_LEN   = 400;
  localparam int DRAIN_CYCLES   = 64;    // longer than a full held-list walk
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;

  // request codes the block ignores
  localparam logic [2:0] REQ_RSVD_FIRST = 3'd5;
  localparam logic [2:0] REQ_RSVD_LAST  = 3'd7;

  typedef struct {
    bit         pause;   // hold the sender until every result is back
    logic [2:0] kind;
    logic [15:0] token;
    logic [7:0] unit;
  } pool_req_t;

  typedef struct {
    logic [2:0]  status;
    logic [7:0]  unit;
    logic [15:0] guest;
    logic        last;
  } pool_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // guest_token[15:0], unit_number[23:16]
  logic [2:0]  s_tuser = '0;   // req_type[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // unit_out[7:0], guest_out[23:8]
  logic [2:0]  m_tuser;        // status[2:0]
  logic        m_tlast;

  pool_req_t    pending_reqs[$];
  pool_result_t expected_results[$];
  int           n_errors = 0;
  int           n_reported = 0;
  int           n_taken = 0;
  int           n_items = 0;

  // predictor state: free order holds unit indices, oldest first
  logic [7:0]  free_units[$];
  bit          unit_held[ROOMS];
  logic [15:0] unit_token[ROOMS];

  room_pool_allocator_unit #(
    .ROOMS      (ROOMS),
    .FIRST_ROOM (FIRST_ROOM)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic void add_result(logic [2:0] status, logic [7:0] unit,
                                     logic [15:0] guest, logic last);
    pool_result_t r;
    r.status = status;
    r.unit   = unit;
    r.guest  = guest;
    r.last   = last;
    expected_results = {expected_results, r};
  endfunction

  // expected results of one accepted request; updates the pool state
  function automatic void predict_pool_results(pool_req_t r);
    int idx;
    int n_held;
    int k;
    logic [7:0] u;
    idx = -1;
    if (int'(r.unit) >= FIRST_ROOM && int'(r.unit) < FIRST_ROOM + ROOMS)
      idx = int'(r.unit) - FIRST_ROOM;
    case (r.kind)
      REQ_OCCUPY: begin
        if (idx < 0 || unit_held[idx]) begin
          add_result(ST_BAD_UNIT, 8'd0, 16'd0, 1'b1);
        end else begin
          unit_held[idx]  = 1'b1;
          unit_token[idx] = r.token;
          for (k = 0; k < free_units.size(); k++) begin
            if (free_units[k] == 8'(idx)) begin
              free_units.delete(k);
              break;
            end
          end
          add_result(ST_OK, r.unit, 16'd0, 1'b1);
        end
      end
      REQ_ASSIGN: begin
        if (free_units.size() == 0) begin
          add_result(ST_NONE_FREE, 8'd0, 16'd0, 1'b1);
        end else begin
          u = free_units[0];
          free_units.delete(0);
          unit_held[u]  = 1'b1;
          unit_token[u] = r.token;
          add_result(ST_OK, 8'(FIRST_ROOM + u), 16'd0, 1'b1);
        end
      end
      REQ_RELEASE: begin
        if (idx < 0 || !unit_held[idx] || free_units.size() >= ROOMS) begin
          add_result(ST_NOT_HELD, 8'd0, 16'd0, 1'b1);
        end else begin
          unit_held[idx] = 1'b0;
          free_units = {free_units, 8'(idx)};
          add_result(ST_OK, r.unit, 16'd0, 1'b1);
        end
      end
      REQ_LIST_FREE: begin
        if (free_units.size() == 0) begin
          add_result(ST_EMPTY, 8'd0, 16'd0, 1'b1);
        end else begin
          for (k = 0; k < free_units.size(); k++)
            add_result(ST_ENTRY, 8'(FIRST_ROOM + free_units[k]), 16'd0,
                       k == free_units.size() - 1);
        end
      end
      REQ_LIST_HELD: begin
        n_held = 0;
        for (k = 0; k < ROOMS; k++)
          if (unit_held[k]) n_held++;
        if (n_held == 0) begin
          add_result(ST_EMPTY, 8'd0, 16'd0, 1'b1);
        end else begin
          for (k = 0; k < ROOMS; k++) begin
            if (unit_held[k]) begin
              n_held--;
              add_result(ST_ENTRY, 8'(FIRST_ROOM + k), unit_token[k], n_held == 0);
            end
          end
        end
      end
      default: begin
        // reserved codes: no result, no state change
      end
    endcase
  endfunction

  task automatic queue_req(logic [2:0] kind, logic [15:0] token, logic [7:0] unit);
    pool_req_t r;
    r.pause = 1'b0;
    r.kind  = kind;
    r.token = token;
    r.unit  = unit;
    pending_reqs = {pending_reqs, r};
    n_items++;
  endtask

  task automatic queue_pause();
    pool_req_t r;
    r.pause = 1'b1;
    r.kind  = REQ_LIST_FREE;
    r.token = '0;
    r.unit  = '0;
    pending_reqs = {pending_reqs, r};
  endtask

  function automatic logic [7:0] pool_unit();
    return 8'(FIRST_ROOM + $urandom_range(0, ROOMS - 1));
  endfunction

  // stimulus, then end-of-run checks
  initial begin
    int ep;
    int pick;
    int k;
    int j;
    int tmp;
    int order[ROOMS];
    bit paused_mid;

    for (k = 0; k < ROOMS; k++) begin
      free_units = {free_units, 8'(k)};
      unit_held[k] = 1'b0;
    end

    // directed: full lists, range edges, duplicates, reserved codes
    queue_req(REQ_LIST_FREE, 16'h0000, 8'h00);
    queue_req(REQ_LIST_HELD, 16'hFFFF, 8'hFF);
    queue_req(REQ_OCCUPY, 16'hFFFF, 8'(FIRST_ROOM));
    queue_req(REQ_OCCUPY, 16'h0000, 8'(FIRST_ROOM + ROOMS - 1));
    queue_req(REQ_OCCUPY, 16'h1234, 8'(FIRST_ROOM));
    queue_req(REQ_OCCUPY, 16'h4321, 8'(FIRST_ROOM - 1));
    queue_req(REQ_OCCUPY, 16'h8001, 8'(FIRST_ROOM + ROOMS));
    queue_req(REQ_OCCUPY, 16'h7FFE, 8'h00);
    queue_req(REQ_OCCUPY, 16'h00FF, 8'hFF);
    queue_req(REQ_OCCUPY, 16'hA5A5, 8'(FIRST_ROOM + 9));
    queue_req(REQ_RELEASE, 16'h0000, 8'(FIRST_ROOM + 10));
    queue_req(REQ_RELEASE, 16'h0000, 8'hFF);
    queue_req(REQ_RELEASE, 16'h0000, 8'(FIRST_ROOM - 1));
    queue_req(REQ_ASSIGN, 16'hAAAA, 8'hFF);
    queue_req(REQ_ASSIGN, 16'h5555, 8'h00);
    queue_req(REQ_RELEASE, 16'hFFFF, 8'(FIRST_ROOM));
    queue_req(REQ_LIST_FREE, 16'h0000, 8'h00);
    queue_req(REQ_LIST_HELD, 16'h0000, 8'h00);
    queue_req(REQ_RSVD_FIRST, 16'hFFFF, 8'hFF);
    queue_req(REQ_RSVD_FIRST + 3'd1, 16'h1111, 8'(FIRST_ROOM));
    queue_req(REQ_RSVD_LAST, 16'h2222, 8'(FIRST_ROOM + 1));
    queue_req(REQ_LIST_HELD, 16'h0000, 8'h00);
    queue_pause();

    // random episodes; the first one fills the pool past empty
    ep = 0;
    paused_mid = 1'b0;
    while (n_items < RANDOM_ITEMS) begin
      if (ep == 0) begin
        // fill: assign beyond exhaustion, then list both sides
        for (k = 0; k < ROOMS + int'($urandom_range(0, 3)); k++)
          queue_req(REQ_ASSIGN, 16'($urandom), 8'($urandom));
        queue_req(REQ_LIST_FREE, 16'($urandom), 8'($urandom));
        queue_req(REQ_LIST_HELD, 16'($urandom), 8'($urandom));
      end else if (ep == 1) begin
        // drain: release every unit in a shuffled order
        for (k = 0; k < ROOMS; k++) order[k] = k;
        for (k = ROOMS - 1; k > 0; k--) begin
          j = $urandom_range(0, k);
          tmp = order[k];
          order[k] = order[j];
          order[j] = tmp;
        end
        for (k = 0; k < ROOMS; k++)
          queue_req(REQ_RELEASE, 16'($urandom), 8'(FIRST_ROOM + order[k]));
        queue_req(REQ_LIST_FREE, 16'($urandom), 8'($urandom));
        queue_req(REQ_LIST_HELD, 16'($urandom), 8'($urandom));
      end else begin
        // mixed traffic, mostly inside the pool
        for (k = 0; k < 20; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 30)
            queue_req(REQ_ASSIGN, 16'($urandom), 8'($urandom));
          else if (pick < 58)
            queue_req(REQ_RELEASE, 16'($urandom), pool_unit());
          else if (pick < 72)
            queue_req(REQ_OCCUPY, 16'($urandom), pool_unit());
          else if (pick < 79)
            queue_req(REQ_LIST_FREE, 16'($urandom), 8'($urandom));
          else if (pick < 86)
            queue_req(REQ_LIST_HELD, 16'($urandom), 8'($urandom));
          else if (pick < 90)
            queue_req(REQ_OCCUPY, 16'($urandom), 8'($urandom));
          else if (pick < 94)
            queue_req(REQ_RELEASE, 16'($urandom), 8'($urandom));
          else
            queue_req(3'($urandom_range(REQ_RSVD_FIRST, REQ_RSVD_LAST)),
                      16'($urandom), 8'($urandom));
        end
      end
      if (!paused_mid && n_items > 250) begin
        paused_mid = 1'b1;
        queue_pause();
      end
      ep = $urandom_range(0, 5);
    end

    // wait for the last request and its results
    @(negedge clk);
    while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_results.size() != 0) begin
      $display("%0d expected results never arrived", expected_results.size());
      n_errors += expected_results.size();
    end

    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // request driver: bursts with random gaps, pauses on markers
  always @(posedge clk) begin : req_driver
    pool_req_t cur_req;
    int gap_left;
    int burst_left;
    bit offer;
    if (rst) begin
      s_tvalid   <= 1'b0;
      s_tdata    <= '0;
      s_tuser    <= '0;
      gap_left   = 0;
      burst_left = $urandom_range(1, 30);
    end else begin
      if (s_tvalid && s_tready) begin
        predict_pool_results(cur_req);
        n_taken++;
      end
      if (!(s_tvalid && !s_tready)) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          if (pending_reqs.size() > 0 && pending_reqs[0].pause &&
              expected_results.size() == 0)
            pending_reqs.delete(0);
          if (pending_reqs.size() > 0 && !pending_reqs[0].pause) begin
            cur_req = pending_reqs[0];
            pending_reqs.delete(0);
            offer = 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
              burst_left = $urandom_range(1, 30);
              gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
          end
        end
        s_tvalid <= offer;
        if (offer) begin
          s_tdata <= {cur_req.unit, cur_req.token};
          s_tuser <= cur_req.kind;
        end
      end
    end
  end

  // result receiver: rotating stall pattern plus one long hold-off
  always @(posedge clk) begin : result_sink
    int rx_cyc;
    int hold_left;
    bit long_hold_done;
    if (rst) begin
      m_tready <= 1'b0;
      rx_cyc = 0;
      hold_left = 0;
      long_hold_done = 1'b0;
    end else begin
      rx_cyc++;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!long_hold_done && n_taken >= HOLD_OFF_AT) begin
        long_hold_done = 1'b1;
        hold_left = HOLD_OFF_LEN;
        m_tready <= 1'b0;
      end else begin
        case ((rx_cyc / 97) % 4)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (rx_cyc % 5 != 0);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk) begin : result_check
    pool_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        n_errors++;
        if (n_reported < MAX_REPORTS) begin
          n_reported++;
          $display("unexpected result: status %0d unit %0d guest %h last %0b",
                   m_tuser, m_tdata[7:0], m_tdata[23:8], m_tlast);
        end
      end else begin
        exp_r = expected_results[0];
        expected_results.delete(0);
        if (m_tuser !== exp_r.status || m_tdata[7:0] !== exp_r.unit ||
            m_tdata[23:8] !== exp_r.guest || m_tlast !== exp_r.last) begin
          n_errors++;
          if (n_reported < MAX_REPORTS) begin
            n_reported++;
            $display("mismatch: expected status %0d unit %0d guest %h last %0b",
                     exp_r.status, exp_r.unit, exp_r.guest, exp_r.last);
            $display("          got      status %0d unit %0d guest %h last %0b",
                     m_tuser, m_tdata[7:0], m_tdata[23:8], m_tlast);
          end
        end
      end
    end
  end

  // watchdog: ends the run when no request is taken for too long
  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (rst || (s_tvalid && s_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule

FILE: files.f
rtl/rpa_pkg.sv
rtl/rpa_free_cell.sv
rtl/rpa_held_cell.sv
rtl/room_pool_allocator_unit.sv
sim/room_pool_allocator_unit_tb.sv
